>>> rtl/core/dad_pkg.sv
// Package for the date adder: field widths, the month-length table,
// the walk-step result struct and the sequencer state type.
// Used by dad_step and date_add_days_top; depends on nothing.
package dad_pkg;

    localparam int DAY_W   = 5;
    localparam int MONTH_W = 4;
    localparam int YEAR_W  = 14;
    localparam int COUNT_W = 16;
    localparam int YLEN_W  = 9;

    // Calendar constants.
    localparam logic [MONTH_W-1:0] JANUARY  = MONTH_W'(1);
    localparam logic [MONTH_W-1:0] FEBRUARY = MONTH_W'(2);
    localparam logic [MONTH_W-1:0] DECEMBER = MONTH_W'(12);
    localparam logic [DAY_W-1:0]   FEB_LEAP = DAY_W'(29);
    localparam logic [DAY_W-1:0]   FEB_NORM = DAY_W'(28);
    localparam logic [YLEN_W-1:0]  YEAR_LEAP = YLEN_W'(366);
    localparam logic [YLEN_W-1:0]  YEAR_NORM = YLEN_W'(365);

    // Divisibility by 25 through the multiplicative inverse of 25 modulo
    // 2**YEAR_W: y is a multiple of 25 exactly when y * INV25 (mod 2**14)
    // does not exceed (2**14 - 1) / 25.
    localparam logic [YEAR_W-1:0] INV25     = YEAR_W'(7209);
    localparam logic [YEAR_W-1:0] DIV25_MAX = YEAR_W'((2 ** YEAR_W - 1) / 25);

    // Sequencer states.
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_CHECK,
        ST_WALK,
        ST_OUT
    } state_t;

    // Result of one pass through the shared step unit.
    typedef struct packed {
        logic [DAY_W-1:0]   dim;
        logic               done;
        logic [DAY_W-1:0]   day;
        logic [MONTH_W-1:0] month;
        logic [YEAR_W-1:0]  year;
        logic [COUNT_W-1:0] count;
    } step_t;

    // Fixed month lengths; February and codes that are no month read zero
    // here (February is patched by the leap rule in the step unit).
    function automatic logic [DAY_W-1:0] month_len(input logic [MONTH_W-1:0] m);
        logic [DAY_W-1:0] len;
        unique case (m)
            4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: len = DAY_W'(31);
            4'd4, 4'd6, 4'd9, 4'd11:                    len = DAY_W'(30);
            default:                                    len = '0;
        endcase
        return len;
    endfunction

endpackage

>>> rtl/core/dad_step.sv
// Shared step unit of the date adder: leap rule, month length, and one
// year, month or in-month advance of the date walk.
// Depends on dad_pkg.
module dad_step (
    input  logic [dad_pkg::DAY_W-1:0]   day_i,
    input  logic [dad_pkg::MONTH_W-1:0] month_i,
    input  logic [dad_pkg::YEAR_W-1:0]  year_i,
    input  logic [dad_pkg::COUNT_W-1:0] count_i,
    output dad_pkg::step_t              step_o
);
    import dad_pkg::*;

    logic [YEAR_W-1:0]  year_inv;
    logic               div4;
    logic               div16;
    logic               div25;
    logic               leap;
    logic [DAY_W-1:0]   dim;
    logic [YLEN_W-1:0]  ylen;
    logic [DAY_W-1:0]   left;
    logic               year_skip;
    logic               fits;
    logic [YEAR_W-1:0]  year_inc;

    // Leap rule: a multiple of 400, or of 4 but not of 100.
    assign year_inv = year_i * INV25;
    assign div4     = (year_i[1:0] == 2'b00);
    assign div16    = (year_i[3:0] == 4'b0000);
    assign div25    = (year_inv <= DIV25_MAX);
    assign leap     = (div16 && div25) || (div4 && !div25);

    // Length of the current month and of the current year.
    assign dim  = (month_i == FEBRUARY) ? (leap ? FEB_LEAP : FEB_NORM) : month_len(month_i);
    assign ylen = leap ? YEAR_LEAP : YEAR_NORM;

    // Days left in the month, and which kind of step applies.
    assign left      = dim - day_i;
    assign year_skip = (day_i == DAY_W'(1)) && (month_i == JANUARY) &&
                       (count_i >= COUNT_W'(ylen));
    assign fits      = (count_i <= COUNT_W'(left));
    assign year_inc  = year_i + YEAR_W'(1);

    // Next date and remaining count.
    always_comb begin
        step_o.dim   = dim;
        step_o.done  = (count_i == '0);
        step_o.day   = day_i;
        step_o.month = month_i;
        step_o.year  = year_i;
        step_o.count = count_i;
        priority if (year_skip) begin
            // From January 1 a whole year can be taken at once.
            step_o.count = count_i - COUNT_W'(ylen);
            step_o.year  = year_inc;
        end else if (fits) begin
            step_o.day   = day_i + count_i[DAY_W-1:0];
            step_o.count = '0;
        end else begin
            // Use up the month plus one day and land on the first of the next.
            step_o.count = count_i - COUNT_W'(left) - COUNT_W'(1);
            step_o.day   = DAY_W'(1);
            if (month_i == DECEMBER) begin
                step_o.month = JANUARY;
                step_o.year  = year_inc;
            end else begin
                step_o.month = month_i + MONTH_W'(1);
            end
        end
    end

endmodule

>>> rtl/core/date_add_days_top.sv
// Top level of the date adder: stream ports, date registers and the
// sequencer that drives the shared step unit.
// Depends on dad_pkg and dad_step.
//
// Usage: a start date and a day count enter on the s_ channel as one beat;
// the date that many days later leaves on the m_ channel as one beat, with
// m_tuser set when the start date was not a real date (it is then echoed).
// Sequence: the beat is loaded and the date is checked; a bad date goes
// straight to the result, else walk steps run until one sees the count
// run out, then the result is shown. A step takes a whole year when the
// walk stands on January 1 and the count covers that year, else at most
// one month, so the count of steps is at most about 12 + years + 12,
// close to 200 for the largest count.
// The step unit is shared by the check and every walk step, so the block
// holds one item at a time: s_tready is high only while idle, and a new beat
// is taken in the cycle after the result beat has been accepted.
// When the receiver stalls, the result stays on m_tdata and m_tuser until
// m_tready is seen. A synchronous low aresetn drops m_tvalid and returns
// the sequencer to idle.
module date_add_days_top (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    // s_tdata, from bit 0: start_day[5], start_month[4], start_year[14],
    // day_count[16], zero pad[1]
    input  logic [39:0] s_tdata,
    output logic        m_tvalid,
    input  logic        m_tready,
    // m_tdata, from bit 0: end_day[5], end_month[4], end_year[14], zero pad[1]
    output logic [23:0] m_tdata,
    // m_tuser, from bit 0: bad_date[1]
    output logic [0:0]  m_tuser
);
    import dad_pkg::*;

    state_t             state_reg, state_next;
    logic [DAY_W-1:0]   day_reg, day_next;
    logic [MONTH_W-1:0] month_reg, month_next;
    logic [YEAR_W-1:0]  year_reg, year_next;
    logic [COUNT_W-1:0] count_reg, count_next;
    logic               bad_reg, bad_next;
    step_t              step;
    logic               in_beat;
    logic               out_beat;
    logic               bad_now;

    // Shared step unit, fed from the date registers.
    dad_step u_step (
        .day_i   (day_reg),
        .month_i (month_reg),
        .year_i  (year_reg),
        .count_i (count_reg),
        .step_o  (step)
    );

    assign in_beat  = s_tvalid && s_tready;
    assign out_beat = m_tvalid && m_tready;

    // The start date is checked for a real month and for a day within its own month length.
    assign bad_now = (month_reg == '0) || (month_reg > DECEMBER) ||
                     (day_reg == '0) || (day_reg > step.dim);

    // Next-state logic.
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:  if (in_beat) state_next = ST_CHECK;
            ST_CHECK: state_next = bad_now ? ST_OUT : ST_WALK;
            ST_WALK:  if (step.done) state_next = ST_OUT;
            ST_OUT:   if (out_beat) state_next = ST_IDLE;
            default:  state_next = ST_IDLE;
        endcase
    end

    // Handshake outputs.
    always_comb begin
        s_tready = 1'b0;
        m_tvalid = 1'b0;
        unique case (state_reg)
            ST_IDLE:  s_tready = 1'b1;
            ST_OUT:   m_tvalid = 1'b1;
            default: begin
                s_tready = 1'b0;
                m_tvalid = 1'b0;
            end
        endcase
    end

    // Datapath: load on the input beat, record the check, advance one step per walk cycle.
    always_comb begin
        day_next   = day_reg;
        month_next = month_reg;
        year_next  = year_reg;
        count_next = count_reg;
        bad_next   = bad_reg;
        if (in_beat) begin
            day_next   = s_tdata[4:0];
            month_next = s_tdata[8:5];
            year_next  = s_tdata[22:9];
            count_next = s_tdata[38:23];
            bad_next   = 1'b0;
        end else if (state_reg == ST_CHECK) begin
            bad_next = bad_now;
        end else if ((state_reg == ST_WALK) && !step.done) begin
            day_next   = step.day;
            month_next = step.month;
            year_next  = step.year;
            count_next = step.count;
        end
    end

    // Control state is reset; the date registers are payload.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge aclk) begin
        day_reg   <= day_next;
        month_reg <= month_next;
        year_reg  <= year_next;
        count_reg <= count_next;
        bad_reg   <= bad_next;
    end

    // Result beat straight from the date registers.
    assign m_tdata = {1'b0, year_reg, month_reg, day_reg};
    assign m_tuser = bad_reg;

endmodule

>>> tb/tb.sv
// Self-checking bench for date_add_days_top: drives start dates and day counts,
// predicts each resulting date and compares it with every result beat.
// Depends on dad_pkg and date_add_days_top.
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import dad_pkg::*;

    localparam int HOLD_CYCLES    = 1500;
    localparam int WATCHDOG_LIMIT = 6000;
    localparam int RANDOM_ITEMS   = 1700;
    localparam int SETTLE_CYCLES  = 8;
    localparam int MAX_REPORTS    = 10;
    localparam int YEAR_SPAN      = 2 ** YEAR_W;

    // Fixed month lengths; February is patched by the leap rule.
    localparam int unsigned MONTH_DAYS [13] = '{0, 31, 28, 31, 30, 31, 30, 31, 31, 30, 31, 30, 31};

    // One input beat, start_day in the lowest bits.
    typedef struct packed {
        logic [COUNT_W-1:0] count;
        logic [YEAR_W-1:0]  year;
        logic [MONTH_W-1:0] month;
        logic [DAY_W-1:0]   day;
    } date_beat_t;

    // One result beat: the date from m_tdata and the flag from m_tuser.
    typedef struct packed {
        logic               bad;
        logic [YEAR_W-1:0]  year;
        logic [MONTH_W-1:0] month;
        logic [DAY_W-1:0]   day;
    } end_date_t;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [39:0] s_tdata = '0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [23:0] m_tdata;
    logic [0:0]  m_tuser;

    end_date_t   pending_dates [$];
    int unsigned mismatch_cnt = 0;
    int unsigned quiet_cycles = 0;
    int unsigned rx_hold_left = 0;
    bit          idle_on = 1'b0;
    bit          tx_live = 1'b0;

    date_add_days_top uut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata (s_tdata),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata (m_tdata),
        .m_tuser (m_tuser)
    );

    always begin
        #10 aclk = 1'b1;
        #10 aclk = 1'b0;
    end

    // Length of a month under the Gregorian leap rule; zero for codes that are no month.
    function automatic int unsigned month_length(int unsigned m, int unsigned y);
        bit leap;
        leap = (y % 400 == 0) || ((y % 4 == 0) && (y % 100 != 0));
        if (m == FEBRUARY)
            return leap ? 29 : 28;
        return (m <= DECEMBER) ? MONTH_DAYS[m] : 0;
    endfunction

    // Walk the date forward month by month; invalid start dates are echoed.
    function automatic end_date_t advance_date(date_beat_t b);
        int unsigned d, m, y, n, left;
        end_date_t   r;
        d = b.day;
        m = b.month;
        y = b.year;
        n = b.count;
        r.bad = 1'b0;
        if (m < JANUARY || m > DECEMBER || d < 1 || d > month_length(m, y)) begin
            r.bad = 1'b1;
        end else begin
            while (n > 0) begin
                left = month_length(m, y) - d;
                if (n <= left) begin
                    d += n;
                    n = 0;
                end else begin
                    n -= left + 1;
                    d = 1;
                    m++;
                    if (m > DECEMBER) begin
                        m = JANUARY;
                        y = (y + 1) % YEAR_SPAN;
                    end
                end
            end
        end
        r.day   = DAY_W'(d);
        r.month = MONTH_W'(m);
        r.year  = YEAR_W'(y);
        return r;
    endfunction

    // Idle length: mostly none, sometimes short, rarely long.
    function automatic int unsigned pick_gap();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (!idle_on || r < 60)
            return 0;
        if (r < 95)
            return $urandom_range(1, 4);
        return $urandom_range(20, 120);
    endfunction

    // Mostly real dates with varied counts, plus some raw noise.
    function automatic date_beat_t random_date();
        date_beat_t  b;
        int unsigned sel;
        b.year  = ($urandom_range(0, 9) == 0) ? YEAR_W'($urandom) : YEAR_W'($urandom_range(1, 9999));
        b.month = MONTH_W'($urandom_range(1, 12));
        b.day   = DAY_W'($urandom_range(1, month_length(b.month, b.year)));
        sel = $urandom_range(0, 99);
        if (sel < 35) begin
            b.count = COUNT_W'($urandom_range(0, 400));
        end else if (sel < 75) begin
            b.count = COUNT_W'($urandom);
        end else if (sel < 85) begin
            // Month end, so the walk crosses a boundary right away.
            b.day   = DAY_W'(month_length(b.month, b.year));
            b.count = COUNT_W'($urandom_range(0, 3));
        end else if (sel < 92) begin
            b.count = COUNT_W'($urandom_range(0, 3000));
        end else begin
            b = date_beat_t'({$urandom, $urandom});
        end
        return b;
    endfunction

    // Offer one beat after a gap, wait for the handshake, record the expected date.
    task automatic send_date(date_beat_t b);
        int unsigned gap;
        gap = pick_gap();
        if (gap > 0) begin
            if (tx_live) begin
                s_tvalid <= 1'b0;
                tx_live = 1'b0;
            end
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {1'b0, b};
        tx_live = 1'b1;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        pending_dates.push_back(advance_date(b));
    endtask

    // Stop offering and wait until every outstanding date has come back.
    task automatic wait_drained();
        if (tx_live) begin
            s_tvalid <= 1'b0;
            tx_live = 1'b0;
        end
        while (pending_dates.size() != 0) @(posedge aclk);
    endtask

    task automatic send_fields(int unsigned d, int unsigned m, int unsigned y, int unsigned n);
        date_beat_t b;
        b.day   = DAY_W'(d);
        b.month = MONTH_W'(m);
        b.year  = YEAR_W'(y);
        b.count = COUNT_W'(n);
        send_date(b);
    endtask

    // Field extremes, leap rules, invalid dates and year wrap, back to back.
    task automatic test_directed();
        idle_on = 1'b0;
        send_fields(1, 1, 1, 0);
        send_fields(17, 6, 0, 0);
        send_fields(31, 12, 16383, 0);
        send_fields(31, 12, 9999, 1);
        send_fields(31, 12, 16383, 1);
        send_fields(28, 2, 1900, 1);
        send_fields(28, 2, 2000, 1);
        send_fields(28, 2, 2100, 1);
        send_fields(29, 2, 2000, 0);
        send_fields(29, 2, 0, 1);
        send_fields(29, 2, 1900, 5);
        send_fields(31, 4, 2021, 3);
        send_fields(0, 5, 2021, 10);
        send_fields(15, 0, 2021, 10);
        send_fields(15, 13, 2021, 10);
        send_fields(31, 15, 16383, 65535);
        send_fields(1, 1, 0, 366);
        send_fields(1, 1, 1, 65535);
        send_fields(1, 1, 16383, 65535);
        send_fields(30, 1, 2023, 30);
        send_fields(31, 1, 2024, 29);
        send_fields(1, 3, 2024, 65535);
        wait_drained();
    endtask

    // Receiver holds off for a long stretch while beats keep coming.
    task automatic test_backpressure();
        idle_on = 1'b0;
        rx_hold_left = HOLD_CYCLES;
        repeat (8) send_date(random_date());
        wait_drained();
    endtask

    // Sender pauses until the block is empty between short bursts.
    task automatic test_pause();
        idle_on = 1'b1;
        repeat (4) begin
            repeat (5) send_date(random_date());
            wait_drained();
        end
    endtask

    // Random beats with idling on both sides, and a stretch without.
    task automatic test_random();
        for (int i = 0; i < RANDOM_ITEMS; i++) begin
            idle_on = !(i >= RANDOM_ITEMS / 2 && i < RANDOM_ITEMS / 2 + 200);
            send_date(random_date());
        end
        wait_drained();
    endtask

    // Receiver: long hold-off on request, else random stalls.
    initial begin : rx_side
        int unsigned stall;
        stall = 0;
        forever begin
            @(posedge aclk);
            if (rx_hold_left > 0) begin
                rx_hold_left--;
                m_tready <= 1'b0;
            end else if (stall > 0) begin
                stall--;
                m_tready <= 1'b0;
            end else begin
                stall = pick_gap();
                m_tready <= (stall == 0);
            end
        end
    end

    // Compare every result beat with the oldest expected date.
    always @(posedge aclk) begin : result_check
        end_date_t got, want;
        if (aresetn && m_tvalid && m_tready) begin
            got = {m_tuser[0], m_tdata[22:0]};
            if (pending_dates.size() == 0) begin
                mismatch_cnt++;
                if (mismatch_cnt <= MAX_REPORTS)
                    $display("unexpected result beat: day %0d month %0d year %0d bad %0b",
                             got.day, got.month, got.year, got.bad);
            end else begin
                want = pending_dates.pop_front();
                if (got.day !== want.day || got.month !== want.month ||
                    got.year !== want.year || got.bad !== want.bad) begin
                    mismatch_cnt++;
                    if (mismatch_cnt <= MAX_REPORTS)
                        $display("date mismatch: expected %0d/%0d/%0d bad %0b, got %0d/%0d/%0d bad %0b",
                                 want.day, want.month, want.year, want.bad,
                                 got.day, got.month, got.year, got.bad);
                end
            end
        end
    end

    // Watchdog: too long without any beat on either side ends the run.
    always @(posedge aclk) begin
        if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // Reset, run the tests in turn, then settle and report.
    initial begin
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_directed();
        test_backpressure();
        test_pause();
        test_random();
        repeat (SETTLE_CYCLES) @(posedge aclk);
        if (mismatch_cnt == 0 && pending_dates.size() == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule
